>>> rtl/mbc_pkg.sv
// shared types and codes of the maze backtracker carver
package mbc_pkg;

    // input command codes (tuser of the slave side)
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_STEP  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // result kinds (tuser of the master side)
    localparam logic [2:0] EV_STARTED = 3'd0;
    localparam logic [2:0] EV_CARVED  = 3'd1;
    localparam logic [2:0] EV_BACK    = 3'd2;
    localparam logic [2:0] EV_NONE    = 3'd3;
    localparam logic [2:0] EV_READ    = 3'd4;

    // carve directions, also the wall bit index
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    // configuration register indexes
    localparam logic CFG_GRID_COLUMNS = 1'b0;
    localparam logic CFG_GRID_ROWS    = 1'b1;
    localparam int   CFG_W            = 7;
    localparam logic [CFG_W-1:0] GRID_RESET = 7'd50;

    // cell word: walls in bits 3..0, visited in bit 4
    localparam int   CELL_W      = 5;
    localparam int   VISITED_BIT = 4;
    localparam logic [CELL_W-1:0] CELL_FRESH = 5'b01111;
    localparam logic [CELL_W-1:0] CELL_ENTRY = 5'b11111;

    typedef enum logic [4:0] {
        ST_INIT_CLR,
        ST_IDLE,
        ST_CLR,
        ST_START_EMIT,
        ST_STEP_TOP,
        ST_NONE_EMIT,
        ST_RD_CUR,
        ST_RD_UP,
        ST_RD_DOWN,
        ST_RD_LEFT,
        ST_RD_RIGHT,
        ST_RD_WAIT,
        ST_PICK,
        ST_WR_CUR,
        ST_CARVE,
        ST_BACK,
        ST_READ_ISSUE,
        ST_READ_WAIT,
        ST_READ_EMIT
    } t_state;

    // which cell the store read port fetches, and where the word lands
    typedef enum logic [2:0] {
        SL_NONE,
        SL_CUR,
        SL_UP,
        SL_DOWN,
        SL_LEFT,
        SL_RIGHT,
        SL_PROBE
    } t_slot;

    typedef enum logic [1:0] {
        CW_NONE,
        CW_CLEAR,
        CW_CUR,
        CW_NB
    } t_cwr;

    typedef enum logic [1:0] {
        DO_HOLD,
        DO_ONE,
        DO_PUSH,
        DO_POP
    } t_depth_op;

    typedef struct packed {
        logic      ld_in;
        logic      clr_start;
        t_cwr      cwr;
        t_slot     slot;
        logic      ld_top;
        logic      ld_pick;
        t_depth_op depth_op;
        logic      emit;
        logic [2:0] ev;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic stack_empty;
        logic has_any;
        logic out_free;
    } t_dp_sts;

endpackage

>>> rtl/mbc_ram.sv
// generic single write, single read memory with registered read data
module mbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/mbc_datapath.sv
// cell store, path stack, neighbour selection and result register
module mbc_datapath #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mbc_pkg::t_dp_cmd  i_cmd,
    output mbc_pkg::t_dp_sts  o_sts,
    input  logic              i_cfg_we,
    input  logic              i_cfg_addr,
    input  logic [6:0]        i_cfg_wdata,
    input  logic [47:0]       i_in_data,
    output logic [23:0]       o_out_data,
    output logic [2:0]        o_out_user,
    output logic              o_out_last,
    output logic              o_out_valid,
    input  logic              i_out_ready
);
    import mbc_pkg::*;

    localparam int XW    = $clog2(MAX_COLUMNS);
    localparam int YW    = $clog2(MAX_ROWS);
    localparam int AW    = XW + YW;
    localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
    localparam int SAW   = $clog2(CELLS);
    localparam int DW    = $clog2(CELLS + 1);
    localparam logic [8:0] MAXC9 = 9'(MAX_COLUMNS);
    localparam logic [8:0] MAXR9 = 9'(MAX_ROWS);

    function automatic logic [5:0] digit_sum(input logic [31:0] v);
        logic [2:0] l1 [8];
        logic [3:0] l2 [4];
        logic [4:0] l3 [2];
        for (int i = 0; i < 8; i++) begin
            l1[i] = {1'b0, v[4*i +: 2]} + {1'b0, v[4*i+2 +: 2]};
        end
        for (int i = 0; i < 4; i++) begin
            l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        end
        for (int i = 0; i < 2; i++) begin
            l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        end
        return {1'b0, l3[0]} + {1'b0, l3[1]};
    endfunction

    // 4 is 1 mod 3, so base-4 digits fold down
    function automatic logic [1:0] mod3_of(input logic [5:0] s);
        logic [3:0] t;
        logic [2:0] u;
        t = {2'b00, s[1:0]} + {2'b00, s[3:2]} + {2'b00, s[5:4]};
        u = {1'b0, t[1:0]} + {1'b0, t[3:2]};
        if (u >= 3'd3) begin
            return 2'(u - 3'd3);
        end
        return u[1:0];
    endfunction

    // configuration
    logic [CFG_W-1:0] r_grid_columns;
    logic [CFG_W-1:0] r_grid_rows;
    logic [8:0]       w_cols;
    logic [8:0]       w_rows;

    // captured input beat
    logic [30:0] r_rnd;
    logic [5:0]  r_rx;
    logic [5:0]  r_ry;
    logic [5:0]  r_dsum;
    logic [1:0]  r_mod3;

    // step working registers
    logic [XW-1:0]     r_cx;
    logic [YW-1:0]     r_cy;
    logic [CELL_W-1:0] r_cur;
    logic [CELL_W-1:0] r_nb [4];
    logic [1:0]        r_pick;
    t_slot             r_cap_sel;

    logic [AW-1:0] r_clr_addr;
    logic [DW-1:0] r_depth;
    logic [DW-1:0] n_depth;
    logic [DW-1:0] w_top_idx;

    // store ports
    logic              w_cell_we;
    logic [AW-1:0]     w_cell_waddr;
    logic [CELL_W-1:0] w_cell_wdata;
    logic [AW-1:0]     w_cell_raddr;
    logic [CELL_W-1:0] w_cell_rdata;
    logic              w_stk_we;
    logic [SAW-1:0]    w_stk_waddr;
    logic [AW-1:0]     w_stk_wdata;
    logic [AW-1:0]     w_stk_rdata;

    logic [3:0]        w_avail;
    logic [2:0]        w_count;
    logic [1:0]        w_k;
    logic [1:0]        w_pick;
    logic [XW-1:0]     w_nx;
    logic [YW-1:0]     w_ny;
    logic [CELL_W-1:0] w_nb_word;
    logic              w_in_range;

    // result register
    logic        r_out_valid;
    logic [2:0]  r_out_kind;
    logic [5:0]  r_out_x;
    logic [5:0]  r_out_y;
    logic [1:0]  r_out_dir;
    logic [3:0]  r_out_walls;
    logic        r_out_vis;
    logic        r_out_fin;
    logic        w_out_free;

    always_comb begin
        if (r_grid_columns == '0) begin
            w_cols = 9'd1;
        end else if (9'(r_grid_columns) > MAXC9) begin
            w_cols = MAXC9;
        end else begin
            w_cols = 9'(r_grid_columns);
        end
        if (r_grid_rows == '0) begin
            w_rows = 9'd1;
        end else if (9'(r_grid_rows) > MAXR9) begin
            w_rows = MAXR9;
        end else begin
            w_rows = 9'(r_grid_rows);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_columns <= GRID_RESET;
            r_grid_rows    <= GRID_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_GRID_COLUMNS) begin
                r_grid_columns <= i_cfg_wdata;
            end
            if (i_cfg_addr == CFG_GRID_ROWS) begin
                r_grid_rows <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_rnd <= i_in_data[30:0];
            r_rx  <= i_in_data[36:31];
            r_ry  <= i_in_data[42:37];
        end
        // free running remainder by three, settled long before the pick
        r_dsum <= digit_sum({1'b0, r_rnd});
        r_mod3 <= mod3_of(r_dsum);
    end

    // neighbour availability, order up, down, left, right
    always_comb begin
        w_avail[DIR_UP]    = (r_cy != '0) && !r_nb[DIR_UP][VISITED_BIT];
        w_avail[DIR_DOWN]  = ((9'(r_cy) + 9'd1) < w_rows) && !r_nb[DIR_DOWN][VISITED_BIT];
        w_avail[DIR_LEFT]  = (r_cx != '0) && !r_nb[DIR_LEFT][VISITED_BIT];
        w_avail[DIR_RIGHT] = ((9'(r_cx) + 9'd1) < w_cols) && !r_nb[DIR_RIGHT][VISITED_BIT];
        w_count = 3'(w_avail[0]) + 3'(w_avail[1]) + 3'(w_avail[2]) + 3'(w_avail[3]);
        case (w_count)
            3'd2:    w_k = {1'b0, r_rnd[0]};
            3'd3:    w_k = r_mod3;
            3'd4:    w_k = r_rnd[1:0];
            default: w_k = 2'd0;
        endcase
    end

    always_comb begin
        logic [1:0] seen;
        logic       found;
        seen   = 2'd0;
        found  = 1'b0;
        w_pick = DIR_UP;
        for (int i = 0; i < 4; i++) begin
            if (w_avail[i] && !found) begin
                if (seen == w_k) begin
                    w_pick = 2'(i);
                    found  = 1'b1;
                end
                seen = seen + 2'd1;
            end
        end
    end

    always_comb begin
        w_nx = r_cx;
        w_ny = r_cy;
        case (r_pick)
            DIR_UP:    w_ny = r_cy - YW'(1);
            DIR_DOWN:  w_ny = r_cy + YW'(1);
            DIR_LEFT:  w_nx = r_cx - XW'(1);
            default:   w_nx = r_cx + XW'(1);
        endcase
        w_nb_word = r_nb[r_pick];
    end

    // store read address
    always_comb begin
        case (i_cmd.slot)
            SL_CUR:   w_cell_raddr = w_stk_rdata;
            SL_UP:    w_cell_raddr = {r_cy - YW'(1), r_cx};
            SL_DOWN:  w_cell_raddr = {r_cy + YW'(1), r_cx};
            SL_LEFT:  w_cell_raddr = {r_cy, r_cx - XW'(1)};
            SL_RIGHT: w_cell_raddr = {r_cy, r_cx + XW'(1)};
            SL_PROBE: w_cell_raddr = {YW'(r_ry), XW'(r_rx)};
            default:  w_cell_raddr = {r_cy, r_cx};
        endcase
    end

    // store write port
    always_comb begin
        w_cell_we    = 1'b1;
        w_cell_waddr = {r_cy, r_cx};
        w_cell_wdata = r_cur;
        case (i_cmd.cwr)
            CW_CLEAR: begin
                w_cell_waddr = r_clr_addr;
                w_cell_wdata = (i_cmd.clr_start && r_clr_addr == '0) ? CELL_ENTRY
                                                                     : CELL_FRESH;
            end
            CW_CUR: begin
                w_cell_wdata = r_cur & ~(CELL_W'(1) << r_pick);
            end
            CW_NB: begin
                w_cell_waddr = {w_ny, w_nx};
                w_cell_wdata = (w_nb_word & ~(CELL_W'(1) << (r_pick ^ 2'd1)))
                             | CELL_W'(1 << VISITED_BIT);
            end
            default: begin
                w_cell_we = 1'b0;
            end
        endcase
    end

    assign w_top_idx = r_depth - DW'(1);

    always_comb begin
        n_depth     = r_depth;
        w_stk_we    = 1'b0;
        w_stk_waddr = r_depth[SAW-1:0];
        w_stk_wdata = {w_ny, w_nx};
        case (i_cmd.depth_op)
            DO_ONE: begin
                n_depth     = DW'(1);
                w_stk_we    = 1'b1;
                w_stk_waddr = '0;
                w_stk_wdata = '0;
            end
            DO_PUSH: begin
                if (r_depth < DW'(CELLS)) begin
                    n_depth  = r_depth + DW'(1);
                    w_stk_we = 1'b1;
                end
            end
            DO_POP: begin
                n_depth = w_top_idx;
            end
            default: begin
                n_depth = r_depth;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth    <= '0;
            r_clr_addr <= '0;
            r_cap_sel  <= SL_NONE;
        end else begin
            r_depth   <= n_depth;
            r_cap_sel <= i_cmd.slot;
            if (i_cmd.cwr == CW_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_top) begin
            r_cx <= w_stk_rdata[XW-1:0];
            r_cy <= w_stk_rdata[AW-1:XW];
        end
        if (i_cmd.ld_pick) begin
            r_pick <= w_pick;
        end
        case (r_cap_sel)
            SL_CUR, SL_PROBE: r_cur <= w_cell_rdata;
            SL_UP:            r_nb[DIR_UP] <= w_cell_rdata;
            SL_DOWN:          r_nb[DIR_DOWN] <= w_cell_rdata;
            SL_LEFT:          r_nb[DIR_LEFT] <= w_cell_rdata;
            SL_RIGHT:         r_nb[DIR_RIGHT] <= w_cell_rdata;
            default: ;
        endcase
    end

    mbc_ram #(
        .WIDTH (CELL_W),
        .DEPTH (1 << AW)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (w_cell_we),
        .i_waddr (w_cell_waddr),
        .i_wdata (w_cell_wdata),
        .i_raddr (w_cell_raddr),
        .o_rdata (w_cell_rdata)
    );

    mbc_ram #(
        .WIDTH (AW),
        .DEPTH (CELLS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (w_stk_waddr),
        .i_wdata (w_stk_wdata),
        .i_raddr (w_top_idx[SAW-1:0]),
        .o_rdata (w_stk_rdata)
    );

    // result register
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_in_range = (9'(r_rx) < MAXC9) && (9'(r_ry) < MAXR9);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_kind  <= i_cmd.ev;
            r_out_x     <= '0;
            r_out_y     <= '0;
            r_out_dir   <= DIR_UP;
            r_out_walls <= '0;
            r_out_vis   <= 1'b0;
            r_out_fin   <= (n_depth == '0);
            case (i_cmd.ev)
                EV_CARVED: begin
                    r_out_x   <= 6'(r_cx);
                    r_out_y   <= 6'(r_cy);
                    r_out_dir <= r_pick;
                end
                EV_BACK: begin
                    r_out_x <= 6'(r_cx);
                    r_out_y <= 6'(r_cy);
                end
                EV_READ: begin
                    r_out_x     <= r_rx;
                    r_out_y     <= r_ry;
                    r_out_walls <= w_in_range ? r_cur[3:0] : 4'hF;
                    r_out_vis   <= w_in_range && r_cur[VISITED_BIT];
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_user  = r_out_kind;
    assign o_out_last  = r_out_fin;
    assign o_out_data  = {5'b0, r_out_vis, r_out_walls, r_out_dir, r_out_y, r_out_x};

    assign o_sts.clr_last    = &r_clr_addr;
    assign o_sts.stack_empty = (r_depth == '0);
    assign o_sts.has_any     = |w_avail;
    assign o_sts.out_free    = w_out_free;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(CELLS))
        else $error("stack depth beyond capacity");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> w_out_free)
        else $error("result loaded over an untaken beat");

    a_carve_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.cwr == CW_NB) |-> (w_avail[r_pick] && !w_nb_word[VISITED_BIT]))
        else $error("carve into an unavailable neighbour");

    a_pop_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.depth_op == DO_POP) |=> (r_depth == $past(r_depth) - DW'(1)))
        else $error("pop did not drop the depth by one");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.depth_op == DO_POP) |-> (r_depth != '0))
        else $error("pop on an empty stack");
endmodule

>>> rtl/mbc_ctrl.sv
// command sequencer of the maze backtracker carver
module mbc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_in_cmd,
    input  mbc_pkg::t_dp_sts i_sts,
    output logic             o_in_ready,
    output mbc_pkg::t_dp_cmd o_cmd
);
    import mbc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_in_ready      = 1'b0;
        o_cmd.ld_in     = 1'b0;
        o_cmd.clr_start = 1'b0;
        o_cmd.cwr       = CW_NONE;
        o_cmd.slot      = SL_NONE;
        o_cmd.ld_top    = 1'b0;
        o_cmd.ld_pick   = 1'b0;
        o_cmd.depth_op  = DO_HOLD;
        o_cmd.emit      = 1'b0;
        o_cmd.ev        = EV_STARTED;
        case (r_state)
            ST_INIT_CLR: begin
                o_cmd.cwr = CW_CLEAR;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.ld_in = i_in_valid;
                if (i_in_valid) begin
                    case (i_in_cmd)
                        CMD_START: n_state = ST_CLR;
                        CMD_STEP:  n_state = ST_STEP_TOP;
                        CMD_READ:  n_state = ST_READ_ISSUE;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CLR: begin
                o_cmd.cwr       = CW_CLEAR;
                o_cmd.clr_start = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_START_EMIT;
                end
            end
            ST_START_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.depth_op = DO_ONE;
                    o_cmd.emit     = 1'b1;
                    o_cmd.ev       = EV_STARTED;
                    n_state        = ST_IDLE;
                end
            end
            ST_STEP_TOP: begin
                // stack top read is under way
                n_state = i_sts.stack_empty ? ST_NONE_EMIT : ST_RD_CUR;
            end
            ST_NONE_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.ev   = EV_NONE;
                    n_state    = ST_IDLE;
                end
            end
            ST_RD_CUR: begin
                o_cmd.slot   = SL_CUR;
                o_cmd.ld_top = 1'b1;
                n_state      = ST_RD_UP;
            end
            ST_RD_UP: begin
                o_cmd.slot = SL_UP;
                n_state    = ST_RD_DOWN;
            end
            ST_RD_DOWN: begin
                o_cmd.slot = SL_DOWN;
                n_state    = ST_RD_LEFT;
            end
            ST_RD_LEFT: begin
                o_cmd.slot = SL_LEFT;
                n_state    = ST_RD_RIGHT;
            end
            ST_RD_RIGHT: begin
                o_cmd.slot = SL_RIGHT;
                n_state    = ST_RD_WAIT;
            end
            ST_RD_WAIT: begin
                n_state = ST_PICK;
            end
            ST_PICK: begin
                o_cmd.ld_pick = 1'b1;
                n_state       = i_sts.has_any ? ST_WR_CUR : ST_BACK;
            end
            ST_WR_CUR: begin
                o_cmd.cwr = CW_CUR;
                n_state   = ST_CARVE;
            end
            ST_CARVE: begin
                if (i_sts.out_free) begin
                    o_cmd.cwr      = CW_NB;
                    o_cmd.depth_op = DO_PUSH;
                    o_cmd.emit     = 1'b1;
                    o_cmd.ev       = EV_CARVED;
                    n_state        = ST_IDLE;
                end
            end
            ST_BACK: begin
                if (i_sts.out_free) begin
                    o_cmd.depth_op = DO_POP;
                    o_cmd.emit     = 1'b1;
                    o_cmd.ev       = EV_BACK;
                    n_state        = ST_IDLE;
                end
            end
            ST_READ_ISSUE: begin
                o_cmd.slot = SL_PROBE;
                n_state    = ST_READ_WAIT;
            end
            ST_READ_WAIT: begin
                n_state = ST_READ_EMIT;
            end
            ST_READ_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.ev   = EV_READ;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule

>>> rtl/maze_backtracker_carver.sv
// top level of the depth-first maze carver
// Slave stream: tuser carries the command (start, step, read cell), tdata the
// random word and the read coordinates. Master stream: one beat per start, step or read command,
// tuser the event kind, tlast set when the path stack is empty afterwards.
// Grid size comes in over the plain write port (index 0 columns, 1 rows) and
// should only be changed between commands.
// A start sweeps every entry of the cell store, one store entry cleared per
// cycle, and leaves cell 0 as the visited entry with all walls up.
// A step goes through the single read port of the cell store: the current
// cell and its four neighbours are fetched one per cycle, then a carve
// writes the two changed cells back, the neighbour once the result
// register is free.
// After reset the cell store is swept to all walls up, unvisited; tready
// stays low meanwhile.
// Results sit in an output register: the next command is accepted while a
// beat waits, but its result holds in the sequencer until the receiver has
// taken the earlier one.
module maze_backtracker_carver #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,  // random_word, read_x, read_y
    input  logic [1:0]  i_s_axis_tuser,  // command
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // cell_x, cell_y, direction, wall_bits, cell_visited
    output logic [2:0]  o_m_axis_tuser,  // event_kind
    output logic        o_m_axis_tlast,  // finished
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [6:0]  i_cfg_wdata
);
    import mbc_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    mbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_cmd   (i_s_axis_tuser),
        .i_sts      (w_sts),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (w_cmd)
    );

    mbc_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_s_axis_tdata),
        .o_out_data  (o_m_axis_tdata),
        .o_out_user  (o_m_axis_tuser),
        .o_out_last  (o_m_axis_tlast),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready)
    );
endmodule

>>> verif/tb_maze_backtracker_carver.sv
// self-checking testbench of the depth-first maze carver, with a scoreboard class
`timescale 1ns / 1ps

module tb_maze_backtracker_carver;
    import mbc_pkg::*;

    localparam int GRID_MAX      = 64;
    localparam int CELL_COUNT    = GRID_MAX * GRID_MAX;
    localparam int ITEM_TARGET   = 1550;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [2:0] kind;
        logic [5:0] x;
        logic [5:0] y;
        logic [1:0] dir;
        logic [3:0] walls;
        logic       vis;
        logic       fin;
    } t_maze_event;

    // tracks the maze the block should be carving, and its pending events
    class t_carve_tracker;
        logic [CELL_W-1:0] cells [CELL_COUNT];
        logic [11:0]       path [CELL_COUNT];
        int unsigned       depth;
        logic [CFG_W-1:0]  cols_reg;
        logic [CFG_W-1:0]  rows_reg;
        t_maze_event       pending_events [$];
        int                fail_count;

        function new();
            foreach (cells[i]) cells[i] = CELL_FRESH;
            foreach (path[i]) path[i] = '0;
            depth      = 0;
            cols_reg   = GRID_RESET;
            rows_reg   = GRID_RESET;
            fail_count = 0;
        endfunction

        function int unsigned clamp(logic [CFG_W-1:0] v);
            if (v < 1) return 1;
            if (v > GRID_MAX) return GRID_MAX;
            return 32'(v);
        endfunction

        function int unsigned grid_cols();
            return clamp(cols_reg);
        endfunction

        function int unsigned grid_rows();
            return clamp(rows_reg);
        endfunction

        function void set_grid(logic idx, logic [CFG_W-1:0] v);
            if (idx == CFG_GRID_COLUMNS) cols_reg = v;
            else rows_reg = v;
        endfunction

        function int unsigned cell_index(int unsigned x, int unsigned y);
            return y * GRID_MAX + x;
        endfunction

        function int outstanding();
            return pending_events.size();
        endfunction

        function void note_command(logic [1:0] cmd, logic [30:0] rnd,
                                   logic [5:0] rx, logic [5:0] ry);
            t_maze_event ev;
            int unsigned cols, rows, cx, cy, nx, ny, count;
            logic [1:0]  dirs [4];
            logic [1:0]  pick;
            logic [11:0] top;
            ev   = '0;
            cols = grid_cols();
            rows = grid_rows();
            case (cmd)
                CMD_START: begin
                    foreach (cells[i]) cells[i] = CELL_FRESH;
                    cells[0] = CELL_ENTRY;
                    path[0]  = '0;
                    depth    = 1;
                    ev.kind  = EV_STARTED;
                end
                CMD_STEP: begin
                    if (depth == 0) begin
                        ev.kind = EV_NONE;
                    end else begin
                        top   = path[depth-1];
                        cx    = 32'(top[5:0]);
                        cy    = 32'(top[11:6]);
                        count = 0;
                        if (cy > 0 && !cells[cell_index(cx, cy-1)][VISITED_BIT]) begin
                            dirs[count] = DIR_UP;
                            count++;
                        end
                        if (cy + 1 < rows && !cells[cell_index(cx, cy+1)][VISITED_BIT]) begin
                            dirs[count] = DIR_DOWN;
                            count++;
                        end
                        if (cx > 0 && !cells[cell_index(cx-1, cy)][VISITED_BIT]) begin
                            dirs[count] = DIR_LEFT;
                            count++;
                        end
                        if (cx + 1 < cols && !cells[cell_index(cx+1, cy)][VISITED_BIT]) begin
                            dirs[count] = DIR_RIGHT;
                            count++;
                        end
                        ev.x = 6'(cx);
                        ev.y = 6'(cy);
                        if (count == 0) begin
                            depth--;
                            ev.kind = EV_BACK;
                        end else begin
                            pick = dirs[rnd % count];
                            nx   = cx;
                            ny   = cy;
                            case (pick)
                                DIR_UP:   ny = cy - 1;
                                DIR_DOWN: ny = cy + 1;
                                DIR_LEFT: nx = cx - 1;
                                default:  nx = cx + 1;
                            endcase
                            // wall bit index equals direction; xor 1 gives the far side
                            cells[cell_index(cx, cy)][pick]          = 1'b0;
                            cells[cell_index(nx, ny)][pick ^ 2'd1]   = 1'b0;
                            cells[cell_index(nx, ny)][VISITED_BIT]   = 1'b1;
                            if (depth < CELL_COUNT) begin
                                path[depth] = {ny[5:0], nx[5:0]};
                                depth++;
                            end
                            ev.kind = EV_CARVED;
                            ev.dir  = pick;
                        end
                    end
                end
                CMD_READ: begin
                    ev.kind  = EV_READ;
                    ev.x     = rx;
                    ev.y     = ry;
                    ev.walls = cells[cell_index(32'(rx), 32'(ry))][3:0];
                    ev.vis   = cells[cell_index(32'(rx), 32'(ry))][VISITED_BIT];
                end
                default: return;
            endcase
            ev.fin = (depth == 0);
            pending_events = {pending_events, ev};
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
                fail_count++;
            end
        endfunction

        function void check_event(t_maze_event got);
            t_maze_event want;
            if (pending_events.size() == 0) begin
                $display("%0t: result beat with nothing expected, kind %0d x %0d y %0d",
                         $time, got.kind, got.x, got.y);
                fail_count++;
                return;
            end
            want = pending_events.pop_front();
            compare_field("event_kind", 32'(want.kind), 32'(got.kind));
            compare_field("cell_x", 32'(want.x), 32'(got.x));
            compare_field("cell_y", 32'(want.y), 32'(got.y));
            compare_field("direction", 32'(want.dir), 32'(got.dir));
            compare_field("wall_bits", 32'(want.walls), 32'(got.walls));
            compare_field("cell_visited", 32'(want.vis), 32'(got.vis));
            compare_field("finished", 32'(want.fin), 32'(got.fin));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [47:0] s_data = '0;
    logic [1:0]  s_user = CMD_START;
    logic        m_ready = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = CFG_GRID_COLUMNS;
    logic [6:0]  cfg_data = '0;
    logic        allow_idle = 1'b1;

    logic        s_ready;
    logic        m_valid;
    logic [23:0] m_data;
    logic [2:0]  m_user;
    logic        m_last;

    t_carve_tracker tracker = new();
    int             sent_items = 0;

    maze_backtracker_carver DUT (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // random_word, read_x, read_y
        .i_s_axis_tuser  (s_user),   // command
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),   // cell_x, cell_y, direction, wall_bits, cell_visited
        .o_m_axis_tuser  (m_user),   // event_kind
        .o_m_axis_tlast  (m_last),   // finished
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: check each accepted beat, then choose the next tready
    always @(posedge i_clk) begin
        t_maze_event got;
        if (rst_n && m_valid && m_ready) begin
            got.kind  = m_user;
            got.x     = m_data[5:0];
            got.y     = m_data[11:6];
            got.dir   = m_data[13:12];
            got.walls = m_data[17:14];
            got.vis   = m_data[18];
            got.fin   = m_last;
            tracker.check_event(got);
        end
        m_ready <= !(allow_idle && $urandom_range(0, 99) < 14);
    end

    task automatic send_command(input logic [1:0] cmd, input logic [30:0] rnd,
                                input logic [5:0] rx, input logic [5:0] ry);
        if (allow_idle && $urandom_range(0, 99) < 14) begin
            s_valid <= 1'b0;
            do @(posedge i_clk); while (allow_idle && $urandom_range(0, 99) < 50);
        end
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= {5'b0, ry, rx, rnd};
        do @(posedge i_clk); while (!s_ready);
        tracker.note_command(cmd, rnd, rx, ry);
        if (cmd != CMD_UNUSED) sent_items++;
    endtask

    task automatic step_maze(input logic [30:0] rnd);
        send_command(CMD_STEP, rnd, 6'($urandom()), 6'($urandom()));
    endtask

    // sender holds off until every pending event is back and the block has settled
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_grid_size(input logic [6:0] cols, input logic [6:0] rows);
        cfg_we   <= 1'b1;
        cfg_addr <= CFG_GRID_COLUMNS;
        cfg_data <= cols;
        @(posedge i_clk);
        tracker.set_grid(CFG_GRID_COLUMNS, cols);
        cfg_addr <= CFG_GRID_ROWS;
        cfg_data <= rows;
        @(posedge i_clk);
        tracker.set_grid(CFG_GRID_ROWS, rows);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [6:0] extreme_size();
        case ($urandom_range(0, 5))
            0: return 7'd0;
            1: return 7'd1;
            2: return 7'd63;
            3: return 7'd64;
            4: return 7'd65;
            default: return 7'd127;
        endcase
    endfunction

    task automatic read_random_cell();
        logic [5:0] rx, ry;
        if ($urandom_range(0, 1) == 0) begin
            rx = 6'($urandom_range(0, tracker.grid_cols() - 1));
            ry = 6'($urandom_range(0, tracker.grid_rows() - 1));
        end else begin
            rx = 6'($urandom());
            ry = 6'($urandom());
        end
        send_command(CMD_READ, 31'($urandom()), rx, ry);
    endtask

    task automatic run_maze(input int budget);
        int change_at, r;
        change_at = ($urandom_range(0, 5) == 0) ? int'($urandom_range(1, budget)) : -1;
        send_command(CMD_START, 31'($urandom()), 6'($urandom()), 6'($urandom()));
        for (int i = 0; i < budget; i++) begin
            if (i == change_at) begin
                wait_for_results();
                set_grid_size(7'($urandom_range(1, 6)), 7'($urandom_range(1, 6)));
            end
            r = int'($urandom_range(0, 99));
            if (r < 8) read_random_cell();
            else if (r < 11) send_command(CMD_UNUSED, 31'($urandom()),
                                          6'($urandom()), 6'($urandom()));
            else if (r < 12) send_command(CMD_START, 31'($urandom()),
                                          6'($urandom()), 6'($urandom()));
            else step_maze(31'($urandom()));
        end
        repeat ($urandom_range(1, 3)) read_random_cell();
    endtask

    initial begin
        int phase, cells, budget;
        logic [6:0] cols, rows;
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;
        // the store is swept after reset before the first beat is taken
        do @(posedge i_clk); while (!s_ready);

        // steps and reads before any start, the unused command, then a start and two steps
        send_command(CMD_STEP, 31'h7FFF_FFFF, 6'd0, 6'd0);
        send_command(CMD_READ, 31'd0, 6'd0, 6'd0);
        send_command(CMD_UNUSED, 31'h7FFF_FFFF, 6'd63, 6'd63);
        send_command(CMD_START, 31'd0, 6'd63, 6'd63);
        step_maze(31'd0);
        step_maze(31'h7FFF_FFFF);
        wait_for_results();

        // zero size acts as a single cell
        set_grid_size(7'd0, 7'd0);
        send_command(CMD_START, 31'h2AAA_AAAA, 6'd21, 6'd42);
        step_maze(31'h5555_5555);
        step_maze(31'd1);
        send_command(CMD_READ, 31'h7FFF_FFFF, 6'd42, 6'd21);
        wait_for_results();

        // a full 2x2 maze, then one step past the end
        set_grid_size(7'd2, 7'd2);
        send_command(CMD_START, 31'd0, 6'd0, 6'd0);
        step_maze(31'd0);
        step_maze(31'h7FFF_FFFF);
        step_maze(31'h5555_5555);
        step_maze(31'h2AAA_AAAA);
        step_maze(31'd1);
        step_maze(31'd2);
        step_maze(31'd3);
        step_maze(31'd0);
        send_command(CMD_READ, 31'd0, 6'd0, 6'd0);
        send_command(CMD_READ, 31'd0, 6'd1, 6'd0);
        send_command(CMD_READ, 31'd0, 6'd0, 6'd1);
        send_command(CMD_READ, 31'd0, 6'd1, 6'd1);

        phase = 0;
        while (sent_items < ITEM_TARGET) begin
            allow_idle <= !(phase >= 8 && phase < 14);
            wait_for_results();
            if (phase == 3) begin
                cols = 7'd64;
                rows = 7'd64;
            end else if ($urandom_range(0, 9) == 0) begin
                cols = extreme_size();
                rows = extreme_size();
            end else begin
                cols = 7'($urandom_range(1, 6));
                rows = 7'($urandom_range(1, 6));
            end
            set_grid_size(cols, rows);
            cells = int'(tracker.grid_cols() * tracker.grid_rows());
            if (phase == 3) budget = 300;
            else if (cells <= 36) budget = 2 * cells + int'($urandom_range(0, 3));
            else budget = int'($urandom_range(40, 100));
            run_maze(budget);
            phase++;
        end

        wait_for_results();
        if (tracker.fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
